### rtl/rcv_pkg.sv
// Shared types and constants for the 5x5 RGB convolution core.
package rcv_pkg;

  localparam int unsigned ColW     = 11;
  localparam int unsigned RowW     = 11;
  localparam int unsigned DimW     = 12;
  localparam int unsigned PixW     = 24;
  localparam int unsigned CoefW    = 40;
  localparam int unsigned KSize    = 5;
  localparam int unsigned LineBits = 3;
  localparam int unsigned AddrW    = LineBits + ColW;
  localparam int unsigned AccW     = 22;
  localparam int unsigned ProdW    = AccW + 16;
  localparam int unsigned JobDepth = 4;
  localparam int unsigned JobPtrW  = 2;

  typedef enum logic [2:0] {
    RegCoef0  = 3'd0,
    RegCoef1  = 3'd1,
    RegCoef2  = 3'd2,
    RegCoef3  = 3'd3,
    RegCoef4  = 3'd4,
    RegScale  = 3'd5,
    RegOffset = 3'd6,
    RegFrame  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [KSize-1:0][CoefW-1:0] coef;
    logic signed [15:0]          scale;
    logic signed [23:0]          offset;
    logic [DimW-1:0]             fw;
    logic [DimW-1:0]             fh;
  } cfg_t;

  typedef struct packed {
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic            last;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } res_t;

endpackage

### rtl/rcv_front.sv
// Front end: configuration registers, input positions, line store writes, job issue.
module rcv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i,
  input  logic                push_i,
  output logic                full_o,
  input  logic                func_i,
  input  logic [7:0]          pixel_red_i,
  input  logic [7:0]          pixel_green_i,
  input  logic [7:0]          pixel_blue_i,
  input  logic                jq_full_i,
  input  logic                back_idle_i,
  output rcv_pkg::wr_t        wr_o,
  output rcv_pkg::job_t       job_o,
  output logic                job_push_o,
  output rcv_pkg::cfg_t       cfg_o
);

  logic [rcv_pkg::KSize-1:0][rcv_pkg::CoefW-1:0] coef_q;
  logic [15:0] scale_q;
  logic [23:0] offset_q;
  logic [21:0] fsize_q;
  logic [rcv_pkg::DimW-1:0] fw_q, fw_d, fh_q, fh_d;
  logic [rcv_pkg::ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [rcv_pkg::RowW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic in_done_q, in_done_d;

  logic start, accept, far, do_emit, last, in_wrap, in_end;
  logic [rcv_pkg::DimW-1:0] w_e, h_e;
  logic [rcv_pkg::ColW-1:0] col_e, ocol_e;
  logic [rcv_pkg::RowW-1:0] row_e, orow_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      scale_q  <= 16'd256;
      offset_q <= '0;
      fsize_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i) inside
        rcv_pkg::RegCoef0, rcv_pkg::RegCoef1, rcv_pkg::RegCoef2,
        rcv_pkg::RegCoef3, rcv_pkg::RegCoef4: coef_q[cfg_index_i] <= cfg_data_i;
        rcv_pkg::RegScale:  scale_q  <= cfg_data_i[15:0];
        rcv_pkg::RegOffset: offset_q <= cfg_data_i[23:0];
        rcv_pkg::RegFrame:  fsize_q  <= cfg_data_i[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start  = ~func_i & (in_done_q | (in_col_q == '0 && in_row_q == '0));
    full_o = jq_full_i | (start & ~back_idle_i);
    accept = push_i & ~full_o;
    w_e    = start ? ({1'b0, fsize_q[10:0]} + 12'd1) : fw_q;
    h_e    = start ? ({1'b0, fsize_q[21:11]} + 12'd1) : fh_q;
    col_e  = in_done_q ? '0 : in_col_q;
    row_e  = in_done_q ? '0 : in_row_q;
    ocol_e = start ? '0 : out_col_q;
    orow_e = start ? '0 : out_row_q;
    if (w_e == 12'd1) begin
      far = (row_e >= 11'd4);
    end else begin
      far = (row_e >= 11'd3) || (row_e == 11'd2 && col_e >= 11'd2);
    end
    do_emit = func_i ? in_done_q : far;
    last    = ({1'b0, orow_e} + 12'd1 >= h_e) && ({1'b0, ocol_e} + 12'd1 >= w_e);
    in_wrap = ({1'b0, col_e} + 12'd1 >= w_e);
    in_end  = in_wrap && ({1'b0, row_e} + 12'd1 >= h_e);

    job_o      = '{x: ocol_e, y: orow_e, last: last};
    job_push_o = accept & do_emit;
    wr_o       = '{en: accept & ~func_i, addr: {row_e[2:0], col_e},
                   data: {pixel_red_i, pixel_green_i, pixel_blue_i}};

    fw_d = fw_q;
    fh_d = fh_q;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    in_done_d = in_done_q;
    if (accept) begin
      if (!func_i) begin
        fw_d = w_e;
        fh_d = h_e;
        in_col_d = in_wrap ? '0 : col_e + 11'd1;
        in_row_d = in_end ? '0 : (in_wrap ? row_e + 11'd1 : row_e);
        in_done_d = in_end & ~(do_emit & last);
        out_col_d = ocol_e;
        out_row_d = orow_e;
      end else if (do_emit) begin
        in_done_d = ~last;
      end
      if (do_emit) begin
        if (last) begin
          out_col_d = '0;
          out_row_d = '0;
        end else if ({1'b0, ocol_e} + 12'd1 >= w_e) begin
          out_col_d = '0;
          out_row_d = orow_e + 11'd1;
        end else begin
          out_col_d = ocol_e + 11'd1;
          out_row_d = orow_e;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 12'd1;
      fh_q <= 12'd1;
      in_col_q <= '0;
      in_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      in_done_q <= 1'b0;
    end else begin
      fw_q <= fw_d;
      fh_q <= fh_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      in_done_q <= in_done_d;
    end
  end

  assign cfg_o = '{coef: coef_q, scale: scale_q, offset: offset_q, fw: fw_q, fh: fh_q};

endmodule

### rtl/rcv_job_fifo.sv
// Job queue between front end and back end.
module rcv_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rcv_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rcv_pkg::job_t data_o,
  output logic          empty_o
);

  rcv_pkg::job_t mem_q [rcv_pkg::JobDepth];
  logic [rcv_pkg::JobPtrW-1:0] wp_q, rp_q;
  logic [rcv_pkg::JobPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (rcv_pkg::JobPtrW+1)'(rcv_pkg::JobDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (rcv_pkg::JobPtrW+1)'(push_i) - (rcv_pkg::JobPtrW+1)'(pop_i);
    end
  end

endmodule

### rtl/rcv_back.sv
// Back end: line store, 25-tap multiply-accumulate, scaling, clamp and result queue.
module rcv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rcv_pkg::wr_t  wr_i,
  input  rcv_pkg::cfg_t cfg_i,
  input  rcv_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          idle_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rcv_pkg::res_t res_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRun  = 5'b00010,
    StSum  = 5'b00100,
    StMul  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [rcv_pkg::PixW-1:0] mem_q [2**rcv_pkg::AddrW];
  logic [rcv_pkg::PixW-1:0] rd_q;
  logic [rcv_pkg::AddrW-1:0] raddr;
  rcv_pkg::job_t job_q;
  logic [2:0] dx_q, dy_q;
  logic signed [7:0] tap_q, tap;
  logic rv_q, issue, inb;
  logic [12:0] xx, yy;
  logic signed [rcv_pkg::AccW-1:0] acc_q [3];
  logic signed [rcv_pkg::ProdW-1:0] prod_q [3];
  logic signed [16:0] pr [3];
  logic signed [rcv_pkg::ProdW:0] t [3];
  logic [7:0] ch [3];
  rcv_pkg::res_t rq_q [2];
  logic wp_q, rp_q;
  logic [1:0] rcnt_q;
  logic rpush, start;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[raddr];
  end

  always_comb begin
    xx    = {2'b00, job_q.x} + {10'd0, dx_q} - 13'd2;
    yy    = {2'b00, job_q.y} + {10'd0, dy_q} - 13'd2;
    inb   = ~xx[12] & ~yy[12] & (xx[11:0] < cfg_i.fw) & (yy[11:0] < cfg_i.fh);
    raddr = {yy[2:0], xx[10:0]};
    tap   = cfg_i.coef[dx_q][8*dy_q +: 8];
    issue = (state_q == StRun);
    start = (state_q == StIdle) && !job_empty_i && (rcnt_q != 2'd2);
    for (int c = 0; c < 3; c++) begin
      pr[c] = $signed({1'b0, rd_q[8*(2-c) +: 8]}) * tap_q;
      t[c]  = (rcv_pkg::ProdW+1)'(prod_q[c]) + (rcv_pkg::ProdW+1)'(cfg_i.offset);
      if (t[c][rcv_pkg::ProdW]) begin
        ch[c] = 8'd0;
      end else if (t[c][rcv_pkg::ProdW-1:16] != '0) begin
        ch[c] = 8'd255;
      end else begin
        ch[c] = t[c][15:8];
      end
    end
    state_d = state_q;
    unique case (state_q)
      StIdle: if (start) state_d = StRun;
      StRun:  if (dx_q == 3'd4 && dy_q == 3'd4) state_d = StSum;
      StSum:  state_d = StMul;
      StMul:  state_d = StFin;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign job_pop_o = start;
  assign idle_o    = (state_q == StIdle);
  assign rpush     = (state_q == StFin);

  always_ff @(posedge clk_i) begin
    if (start) job_q <= job_i;
    tap_q <= inb ? tap : 8'sd0;
    for (int c = 0; c < 3; c++) begin
      if (start) begin
        acc_q[c] <= '0;
      end else if (rv_q) begin
        acc_q[c] <= acc_q[c] + rcv_pkg::AccW'(pr[c]);
      end
      if (state_q == StMul) prod_q[c] <= cfg_i.scale * acc_q[c];
    end
    if (rpush) rq_q[wp_q] <= '{red: ch[0], green: ch[1], blue: ch[2], eof: job_q.last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dx_q <= '0;
      dy_q <= '0;
      rv_q <= 1'b0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      rcnt_q <= '0;
    end else begin
      state_q <= state_d;
      rv_q <= issue;
      if (start) begin
        dx_q <= '0;
        dy_q <= '0;
      end else if (issue) begin
        if (dy_q == 3'd4) begin
          dy_q <= '0;
          dx_q <= dx_q + 3'd1;
        end else begin
          dy_q <= dy_q + 3'd1;
        end
      end
      if (rpush) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      rcnt_q <= rcnt_q + 2'(rpush) - 2'(pop_i && !empty_o);
    end
  end

  assign empty_o = (rcnt_q == '0);
  assign res_o   = rq_q[rp_q];

endmodule

### rtl/rgb_convolution_5x5_core.sv
// Top level of the 5x5 RGB convolution core.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | push_i / full_o        | func_i, pixel_red_i, pixel_green_i, pixel_blue_i
//  result   | pop_i / empty_o        | out_red_o, out_green_o, out_blue_o, end_of_frame_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front end writes each accepted pixel to the line store and issues jobs. Each job then
// passes through the back end in order: the idle state takes it, 25 line store reads, then
// the accumulate, scale and clamp states; a new job is taken only once the back end is idle.
// full_o rises when the job queue is full, on a pixel while a job waits in the queue, and
// on the first pixel of a frame until all jobs of the previous frame are done.
// Reset clears control state and the configuration registers only.
module rgb_convolution_5x5_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [39:0] cfg_data_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        func_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        end_of_frame_o
);

  rcv_pkg::wr_t  wr;
  rcv_pkg::cfg_t cfg;
  rcv_pkg::job_t job_in, job_out;
  rcv_pkg::res_t res;
  logic job_push, job_pop, jq_full, jq_empty, back_idle;

  assign cfg_ready_o = 1'b1;

  // a pixel waits while a job is queued so the line store write never overtakes the window
  rcv_front u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .push_i, .full_o, .func_i, .pixel_red_i, .pixel_green_i, .pixel_blue_i,
    .jq_full_i(jq_full | (~jq_empty & ~func_i)), .back_idle_i(back_idle & jq_empty),
    .wr_o(wr), .job_o(job_in), .job_push_o(job_push), .cfg_o(cfg)
  );

  rcv_job_fifo u_jobs (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .full_o(jq_full),
    .pop_i(job_pop), .data_o(job_out), .empty_o(jq_empty)
  );

  rcv_back u_back (
    .clk_i, .rst_ni, .wr_i(wr), .cfg_i(cfg), .job_i(job_out),
    .job_empty_i(jq_empty), .job_pop_o(job_pop), .idle_o(back_idle),
    .pop_i, .empty_o, .res_o(res)
  );

  assign out_red_o      = res.red;
  assign out_green_o    = res.green;
  assign out_blue_o     = res.blue;
  assign end_of_frame_o = res.eof;

endmodule

### rtl/rcv_checker.sv
// Port-level checks for the convolution core, bound to the top level.
module rcv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       pop_i,
  input logic       empty_o,
  input logic [7:0] out_red_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_blue_o,
  input logic       end_of_frame_o
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty_o)
    else $error("result queue not empty in reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port stalled");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_red_o) && $stable(out_green_o)
      && $stable(out_blue_o) && $stable(end_of_frame_o))
    else $error("waiting result changed");

  a_first_result_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty_o) |-> $past(empty_o, 2) || $past(pop_i) || $past(pop_i, 2))
    else $error("result appeared too early");

endmodule

bind rgb_convolution_5x5_core rcv_checker u_rcv_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .pop_i, .empty_o,
  .out_red_o, .out_green_o, .out_blue_o, .end_of_frame_o
);
